@@ design/jha_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jha_pkg: shared types and constants of the joint histogram accumulator
// Item kinds, status codes, register indexes and the queue entry format.
// ---------------------------------------------------------------------------
package jha_pkg;

	// Field widths fixed by the interface
	localparam int PIX_W     = 16;
	localparam int KIND_W    = 2;
	localparam int QBIN_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int RESULT_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	// Largest supported bin count and the widths that follow from it
	localparam int MAX_BINS  = 4096;
	localparam int MAX_BIN_W = 12;
	// Width of range compares: holds a full quotient and MAX_BINS
	localparam int RANGE_W   = PIX_W + 1;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE_A = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE_B = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH_A   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH_B   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_STENC = 2'd2;

	// Operations handed from the front to the back
	typedef enum logic [1:0] {
		OP_COUNT  = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	// One queue entry
	typedef struct packed {
		op_t                  op;
		logic [STATUS_W-1:0]  status;
		logic [MAX_BIN_W-1:0] bin_a;
		logic [MAX_BIN_W-1:0] bin_b;
	} entry_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

@@ design/jha_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jha_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module jha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/jha_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jha_div: iterative unsigned divider for bin mapping
// Restoring division, one quotient bit per cycle; a zero divisor acts as one.
// ---------------------------------------------------------------------------
module jha_div
	import jha_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [PIX_W-1:0] dividend,
	input  logic [PIX_W-1:0] divisor,
	output logic             running,
	output logic [PIX_W-1:0] quotient
);

	localparam int CNT_W = $clog2(PIX_W);

	logic [PIX_W-1:0] rem_q;
	logic [PIX_W-1:0] quo_q;
	logic [PIX_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic [PIX_W:0]   shifted;
	logic [PIX_W:0]   trial;
	logic             borrow;

	// Trial subtract of the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[PIX_W-1]};
		trial   = shifted - {1'b0, dvs_q};
		borrow  = trial[PIX_W];
	end

	// Control: run for one step per quotient bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(PIX_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// Datapath: load operands, then shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= (divisor == '0) ? PIX_W'(1) : divisor;
		end else if (run_q) begin
			rem_q <= borrow ? shifted[PIX_W-1:0] : trial[PIX_W-1:0];
			quo_q <= {quo_q[PIX_W-2:0], ~borrow};
		end
	end

	assign running  = run_q;
	assign quotient = quo_q;

endmodule

@@ design/jha_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jha_queue: short queue between front and back
// Holds classified operations so that either side may stall on its own.
// ---------------------------------------------------------------------------
module jha_queue
	import jha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  entry_t      push_entry,
	input  logic        pop,
	output entry_t      head,
	output queue_stat_t stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);

endmodule

@@ design/jha_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jha_front: item intake and classification
// Takes items, maps pixel samples to bins, checks ranges and queues work.
// ---------------------------------------------------------------------------
module jha_front
	import jha_pkg::*;
#(
	parameter int BINS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KIND_W-1:0] kind,
	input  logic [PIX_W-1:0]  pixel_a,
	input  logic [PIX_W-1:0]  pixel_b,
	input  logic              inside_stencil,
	input  logic [QBIN_W-1:0] query_bin_a,
	input  logic [QBIN_W-1:0] query_bin_b,
	input  logic [PIX_W-1:0]  bin_width_a,
	input  logic [PIX_W-1:0]  bin_width_b,
	input  logic              reverse_stencil,
	input  logic              hold,
	input  queue_stat_t       qstat,
	output logic              busy,
	output logic              push,
	output entry_t            push_entry
);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_DIV  = 2'b10
	} fstate_t;

	fstate_t          state_q;
	logic             accept;
	logic             need_div;
	logic             div_start;
	logic             div_run;
	logic             div_run_b;
	logic [PIX_W-1:0] quo_a;
	logic [PIX_W-1:0] quo_b;
	entry_t           entry_imm;
	entry_t           entry_div;

	// Bin dividers, run side by side
	jha_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pixel_a),
		.divisor  (bin_width_a),
		.running  (div_run),
		.quotient (quo_a)
	);

	jha_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pixel_b),
		.divisor  (bin_width_b),
		.running  (div_run_b),
		.quotient (quo_b)
	);

	// Classify an item at intake
	always_comb begin
		busy      = (state_q != F_IDLE) || qstat.full || hold;
		accept    = start && !busy;
		need_div  = (kind == KIND_PIXEL) && (inside_stencil != reverse_stencil);
		div_start = accept && need_div;

		entry_imm.op     = OP_REPORT;
		entry_imm.status = ST_OK;
		entry_imm.bin_a  = MAX_BIN_W'(query_bin_a);
		entry_imm.bin_b  = MAX_BIN_W'(query_bin_b);
		case (kind)
			KIND_READ: begin
				if (RANGE_W'(query_bin_a) >= RANGE_W'(BINS)) begin
					entry_imm.status = ST_RANGE_A;
				end else if (RANGE_W'(query_bin_b) >= RANGE_W'(BINS)) begin
					entry_imm.status = ST_RANGE_B;
				end else begin
					entry_imm.op = OP_READ;
				end
			end
			KIND_CLEAR: begin
				entry_imm.op = OP_CLEAR;
			end
			default: begin
				entry_imm.op = OP_REPORT;
			end
		endcase
	end

	// Range check the bins once division is done
	always_comb begin
		entry_div.op     = OP_REPORT;
		entry_div.status = ST_OK;
		entry_div.bin_a  = quo_a[MAX_BIN_W-1:0];
		entry_div.bin_b  = quo_b[MAX_BIN_W-1:0];
		if (RANGE_W'(quo_a) >= RANGE_W'(BINS)) begin
			entry_div.status = ST_RANGE_A;
		end else if (RANGE_W'(quo_b) >= RANGE_W'(BINS)) begin
			entry_div.status = ST_RANGE_B;
		end else begin
			entry_div.op = OP_COUNT;
		end
	end

	// Queue either the intake entry or the divided one
	always_comb begin
		push       = 1'b0;
		push_entry = entry_imm;
		if (state_q == F_IDLE) begin
			push = accept && !need_div;
		end else if (!div_run && !div_run_b && !qstat.full) begin
			push       = 1'b1;
			push_entry = entry_div;
		end
	end

	// Sequencer: wait for the dividers, then hand over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (div_start) begin
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/jha_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jha_back: histogram store and update engine
// Runs queued operations on the three count stores and drives each result.
// ---------------------------------------------------------------------------
module jha_back
	import jha_pkg::*;
#(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  entry_t              head,
	input  queue_stat_t         qstat,
	output logic                pop,
	output logic                init,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [RESULT_W-1:0] joint_count,
	output logic [RESULT_W-1:0] marginal_a_count,
	output logic [RESULT_W-1:0] marginal_b_count
);

	localparam int BIN_W   = $clog2(BINS);
	localparam int JADDR_W = 2 * BIN_W;
	localparam int MDEPTH  = 1 << BIN_W;
	localparam int JDEPTH  = 1 << JADDR_W;

	typedef enum logic [3:0] {
		B_IDLE   = 4'b0001,
		B_READ   = 4'b0010,
		B_UPDATE = 4'b0100,
		B_CLEAR  = 4'b1000
	} bstate_t;

	bstate_t               state_q;
	entry_t                op_q;
	logic [JADDR_W-1:0]    clr_q;
	logic                  init_q;
	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic [RESULT_W-1:0]   joint_q;
	logic [RESULT_W-1:0]   marg_a_q;
	logic [RESULT_W-1:0]   marg_b_q;

	logic                  we;
	logic [BIN_W-1:0]      bin_a;
	logic [BIN_W-1:0]      bin_b;
	logic [BIN_W-1:0]      m_waddr_a;
	logic [BIN_W-1:0]      m_waddr_b;
	logic [JADDR_W-1:0]    j_waddr;
	logic [COUNT_BITS-1:0] wdata_a;
	logic [COUNT_BITS-1:0] wdata_b;
	logic [COUNT_BITS-1:0] wdata_j;
	logic [COUNT_BITS-1:0] rdata_a;
	logic [COUNT_BITS-1:0] rdata_b;
	logic [COUNT_BITS-1:0] rdata_j;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (c == '1) ? c : c + COUNT_BITS'(1);
	endfunction

	assign bin_a = op_q.bin_a[BIN_W-1:0];
	assign bin_b = op_q.bin_b[BIN_W-1:0];

	// Write port: clear sweep or saturating increment
	always_comb begin
		we        = 1'b0;
		m_waddr_a = bin_a;
		m_waddr_b = bin_b;
		j_waddr   = {bin_a, bin_b};
		wdata_a   = sat_inc(rdata_a);
		wdata_b   = sat_inc(rdata_b);
		wdata_j   = sat_inc(rdata_j);
		if (state_q == B_CLEAR) begin
			we        = 1'b1;
			m_waddr_a = clr_q[BIN_W-1:0];
			m_waddr_b = clr_q[BIN_W-1:0];
			j_waddr   = clr_q;
			wdata_a   = '0;
			wdata_b   = '0;
			wdata_j   = '0;
		end else if (state_q == B_UPDATE && op_q.op == OP_COUNT) begin
			we = 1'b1;
		end
	end

	jha_ram #(.WIDTH(COUNT_BITS), .DEPTH(MDEPTH)) u_hist_first (
		.clk   (clk),
		.we    (we),
		.waddr (m_waddr_a),
		.wdata (wdata_a),
		.raddr (bin_a),
		.rdata (rdata_a)
	);

	jha_ram #(.WIDTH(COUNT_BITS), .DEPTH(MDEPTH)) u_hist_second (
		.clk   (clk),
		.we    (we),
		.waddr (m_waddr_b),
		.wdata (wdata_b),
		.raddr (bin_b),
		.rdata (rdata_b)
	);

	jha_ram #(.WIDTH(COUNT_BITS), .DEPTH(JDEPTH)) u_hist_joint (
		.clk   (clk),
		.we    (we),
		.waddr (j_waddr),
		.wdata (wdata_j),
		.raddr ({bin_a, bin_b}),
		.rdata (rdata_j)
	);

	assign pop = (state_q == B_IDLE) && !qstat.empty;

	// Sequencer: take an entry, read, update or sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			init_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						case (head.op)
							OP_COUNT, OP_READ: begin
								state_q <= B_READ;
							end
							OP_CLEAR: begin
								state_q <= B_CLEAR;
								clr_q   <= '0;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				B_READ: begin
					state_q <= B_UPDATE;
				end
				B_UPDATE: begin
					state_q <= B_IDLE;
					done_q  <= 1'b1;
				end
				B_CLEAR: begin
					clr_q <= clr_q + JADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= B_IDLE;
						init_q  <= 1'b0;
						done_q  <= !init_q;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Latch the entry in hand and build the result beat
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q     <= head;
			status_q <= head.status;
			joint_q  <= '0;
			marg_a_q <= '0;
			marg_b_q <= '0;
		end else if (state_q == B_CLEAR) begin
			status_q <= ST_OK;
			joint_q  <= '0;
			marg_a_q <= '0;
			marg_b_q <= '0;
		end else if (state_q == B_UPDATE && op_q.op == OP_READ) begin
			joint_q  <= RESULT_W'(rdata_j);
			marg_a_q <= RESULT_W'(rdata_a);
			marg_b_q <= RESULT_W'(rdata_b);
		end
	end

	assign init             = init_q;
	assign done             = done_q;
	assign status           = status_q;
	assign joint_count      = joint_q;
	assign marginal_a_count = marg_a_q;
	assign marginal_b_count = marg_b_q;

endmodule

@@ design/joint_histogram_accumulator_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joint_histogram_accumulator_unit: joint and marginal intensity histograms
// Bins pixel pairs, counts them into three saturating stores and reads back.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+------------------------------------------
//   item in  | start / busy       | kind, pixel_a, pixel_b, inside_stencil,
//            |                    | query_bin_a, query_bin_b
//   result   | done (one cycle)   | status, joint_count, marginal_a_count,
//            |                    | marginal_b_count
//   config   | cfg_we             | cfg_index, cfg_wdata
//
// A pixel pair that passes the stencil test waits in the front for the
// iterative bin dividers (one quotient bit a cycle) before it is queued, and
// busy stays high until then; other items are queued as they are accepted.
// The back reads and then updates for a count or a read, and answers a
// report from idle; a clear sweeps the joint store, 2^(2*clog2(BINS)) entries
// (65536 at the defaults); the same sweep runs after reset with busy held high.
// Busy also rises while the queue is full. The receiver cannot stall: each
// result beat is shown for one cycle only.
// ---------------------------------------------------------------------------
module joint_histogram_accumulator_unit
	import jha_pkg::*;
#(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [KIND_W-1:0]    kind,
	input  logic [PIX_W-1:0]     pixel_a,
	input  logic [PIX_W-1:0]     pixel_b,
	input  logic                 inside_stencil,
	input  logic [QBIN_W-1:0]    query_bin_a,
	input  logic [QBIN_W-1:0]    query_bin_b,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [RESULT_W-1:0]  joint_count,
	output logic [RESULT_W-1:0]  marginal_a_count,
	output logic [RESULT_W-1:0]  marginal_b_count,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [PIX_W-1:0] bin_width_a_q;
	logic [PIX_W-1:0] bin_width_b_q;
	logic             reverse_stencil_q;
	logic             push;
	logic             pop;
	logic             init;
	entry_t           push_entry;
	entry_t           head;
	queue_stat_t      qstat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_a_q     <= PIX_W'(1);
			bin_width_b_q     <= PIX_W'(1);
			reverse_stencil_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIN_WIDTH_A:   bin_width_a_q     <= cfg_wdata;
				REG_BIN_WIDTH_B:   bin_width_b_q     <= cfg_wdata;
				REG_REVERSE_STENC: reverse_stencil_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	jha_front #(.BINS(BINS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.kind            (kind),
		.pixel_a         (pixel_a),
		.pixel_b         (pixel_b),
		.inside_stencil  (inside_stencil),
		.query_bin_a     (query_bin_a),
		.query_bin_b     (query_bin_b),
		.bin_width_a     (bin_width_a_q),
		.bin_width_b     (bin_width_b_q),
		.reverse_stencil (reverse_stencil_q),
		.hold            (init),
		.qstat           (qstat),
		.busy            (busy),
		.push            (push),
		.push_entry      (push_entry)
	);

	jha_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (qstat)
	);

	jha_back #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.qstat            (qstat),
		.pop              (pop),
		.init             (init),
		.done             (done),
		.status           (status),
		.joint_count      (joint_count),
		.marginal_a_count (marginal_a_count),
		.marginal_b_count (marginal_b_count)
	);

endmodule
